// File: rtl/sector_peak_finder_core_assert.svh
// Assertion macros for the sector peak finder core.
// Used by the top level; no other dependencies.
`ifndef SECTOR_PEAK_FINDER_CORE_ASSERT_SVH
`define SECTOR_PEAK_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spf same-cycle check failed");

// Next-cycle implication, masked during reset.
`define SPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spf next-cycle check failed");

`endif

// File: rtl/spf_pkg.sv
// Shared types, codes and helpers for the sector peak finder.
// No dependencies; the interfaces and all modules import this package.
package spf_pkg;

    localparam int DEF_MAX_SAMPLES = 256;
    localparam int DEF_VALUE_BITS  = 6;

    localparam int ACTION_W = 2;
    localparam int SECTOR_W = 4;
    localparam int VALUE_W  = 6;
    localparam int RANK_W   = 2;
    localparam int SIZE_W   = 9;
    localparam int LOC_W    = 8;
    localparam int OCC_W    = 14;
    localparam int CNT_W    = 2;
    localparam int SUM_W    = 11;
    localparam int NRANK    = 3;

    localparam logic [ACTION_W-1:0] ACT_START  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    localparam logic KIND_CHAN = 1'b0;
    localparam logic KIND_BEST = 1'b1;

    localparam logic [RANK_W-1:0] RANK_FIRST = 2'd0;
    localparam logic [RANK_W-1:0] RANK_LAST  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 9'd511;
    localparam logic [OCC_W-1:0]  OCC_MAX  = 14'd16383;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SECTOR_W-1:0] sector;
        logic                ring;
        logic [VALUE_W-1:0]  sample_value;
        logic                channel_end;
    } t_item;

    // Three records captured together, served one rank at a time.
    typedef struct packed {
        logic                            kind;
        logic [NRANK-1:0][SECTOR_W-1:0]  sec;
        logic [NRANK-1:0]                ring;
        logic [NRANK-1:0][SIZE_W-1:0]    size;
        logic [NRANK-1:0][LOC_W-1:0]     loc;
        logic [NRANK-1:0][OCC_W-1:0]     occ;
        logic [CNT_W-1:0]                cnt;
        logic [OCC_W-1:0]                total;
    } t_batch;

    function automatic logic [OCC_W-1:0] sat_occ(input logic [OCC_W-1:0] a,
                                                 input logic [OCC_W-1:0] b);
        logic [OCC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OCC_W] ? OCC_MAX : s[OCC_W-1:0];
    endfunction

endpackage

// File: rtl/spf_if.sv
// Valid/ready channel interfaces for sample requests and peak records.
// Depends on spf_pkg.
interface spf_in_if;
    import spf_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SECTOR_W-1:0] sector;
    logic                ring;
    logic [VALUE_W-1:0]  sample_value;
    logic                channel_end;

    modport source (output valid, action, sector, ring, sample_value, channel_end,
                    input ready);
    modport sink   (input valid, action, sector, ring, sample_value, channel_end,
                    output ready);
endinterface

interface spf_out_if;
    import spf_pkg::*;

    logic                valid;
    logic                ready;
    logic                record_kind;
    logic [SECTOR_W-1:0] out_sector;
    logic                out_ring;
    logic [RANK_W-1:0]   rank;
    logic [SIZE_W-1:0]   peak_size;
    logic [LOC_W-1:0]    peak_location;
    logic [OCC_W-1:0]    peak_occupancy;
    logic [CNT_W-1:0]    peak_count;
    logic [OCC_W-1:0]    total_occupancy;
    logic                last;

    modport source (output valid, record_kind, out_sector, out_ring, rank, peak_size,
                    peak_location, peak_occupancy, peak_count, total_occupancy, last,
                    input ready);
    modport sink   (input valid, record_kind, out_sector, out_ring, rank, peak_size,
                    peak_location, peak_occupancy, peak_count, total_occupancy, last,
                    output ready);
endinterface

// File: rtl/spf_track.sv
// Window scoring, channel top-3 list and event-wide top-3 list.
// Depends on spf_pkg; next state and the record batch are combinational.
module spf_track #(
    parameter int MAX_SAMPLES = spf_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_BITS  = spf_pkg::DEF_VALUE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  spf_pkg::t_item i_item,
    output spf_pkg::t_batch o_batch
);
    import spf_pkg::*;

    localparam int VB    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);

    logic [3:0][VB-1:0]          r_hist,  n_hist;
    logic [IDX_W-1:0]            r_idx,   n_idx;
    logic [OCC_W-1:0]            r_run,   n_run;
    logic [NRANK-1:0]            r_flags, n_flags;
    logic [NRANK-1:0][SIZE_W-1:0] r_csize, n_csize;
    logic [NRANK-1:0][LOC_W-1:0]  r_cloc,  n_cloc;
    logic [NRANK-1:0][OCC_W-1:0]  r_cocc,  n_cocc;
    logic [CNT_W-1:0]            r_cpeaks, n_cpeaks;
    logic [OCC_W-1:0]            r_ctotal, n_ctotal;
    logic [NRANK-1:0][SIZE_W-1:0] r_bsize, n_bsize;
    logic [NRANK-1:0][SECTOR_W-1:0] r_bsec, n_bsec;
    logic [NRANK-1:0]            r_bring, n_bring;
    logic [NRANK-1:0][LOC_W-1:0]  r_bloc,  n_bloc;

    logic [VB-1:0]    v;
    logic [SUM_W-1:0] sum_w;
    logic [SIZE_W-1:0] sum;
    logic [LOC_W-1:0] loc;
    logic [OCC_W-1:0] centre;

    always_comb begin
        n_hist   = r_hist;
        n_idx    = r_idx;
        n_run    = r_run;
        n_flags  = r_flags;
        n_csize  = r_csize;
        n_cloc   = r_cloc;
        n_cocc   = r_cocc;
        n_cpeaks = r_cpeaks;
        n_ctotal = r_ctotal;
        n_bsize  = r_bsize;
        n_bsec   = r_bsec;
        n_bring  = r_bring;
        n_bloc   = r_bloc;

        v      = VB'(i_item.sample_value);
        sum_w  = SUM_W'(r_hist[0]) + SUM_W'(r_hist[1]) + SUM_W'(r_hist[2])
               + SUM_W'(r_hist[3]) + SUM_W'(v);
        sum    = (sum_w > SUM_W'(SIZE_MAX)) ? SIZE_MAX : sum_w[SIZE_W-1:0];
        loc    = LOC_W'(r_idx - IDX_W'(2));
        centre = OCC_W'(r_hist[1]);

        if (i_item.action == ACT_SAMPLE && r_idx < IDX_W'(MAX_SAMPLES)) begin
            if (r_idx >= IDX_W'(4)) begin
                if (sum == '0) begin
                    // close the run: write its count into every rank it placed
                    for (int r = 0; r < NRANK; r++) begin
                        if (r_flags[r]) begin
                            n_cocc[r] = r_run;
                        end
                    end
                    n_run   = '0;
                    n_flags = '0;
                end else begin
                    if (sum > r_bsize[0]) begin
                        n_bsize[2] = r_bsize[1]; n_bsec[2] = r_bsec[1];
                        n_bring[2] = r_bring[1]; n_bloc[2] = r_bloc[1];
                        n_bsize[1] = r_bsize[0]; n_bsec[1] = r_bsec[0];
                        n_bring[1] = r_bring[0]; n_bloc[1] = r_bloc[0];
                        n_bsize[0] = sum; n_bsec[0] = i_item.sector;
                        n_bring[0] = i_item.ring; n_bloc[0] = loc;
                    end else if (sum > r_bsize[1]) begin
                        n_bsize[2] = r_bsize[1]; n_bsec[2] = r_bsec[1];
                        n_bring[2] = r_bring[1]; n_bloc[2] = r_bloc[1];
                        n_bsize[1] = sum; n_bsec[1] = i_item.sector;
                        n_bring[1] = i_item.ring; n_bloc[1] = loc;
                    end else if (sum > r_bsize[2]) begin
                        n_bsize[2] = sum; n_bsec[2] = i_item.sector;
                        n_bring[2] = i_item.ring; n_bloc[2] = loc;
                    end

                    n_run    = sat_occ(r_run, centre);
                    n_ctotal = sat_occ(r_ctotal, centre);

                    // an insert keeps the occupancy already in its own slot
                    if (sum > r_csize[0]) begin
                        n_cpeaks = CNT_W'(1);
                        if (r_csize[0] != '0) begin
                            n_cpeaks = CNT_W'(2);
                            if (r_csize[1] != '0) begin
                                n_cpeaks   = CNT_W'(3);
                                n_csize[2] = r_csize[1];
                                n_cloc[2]  = r_cloc[1];
                                n_cocc[2]  = r_cocc[1];
                            end
                            n_csize[1] = r_csize[0];
                            n_cloc[1]  = r_cloc[0];
                            n_cocc[1]  = r_cocc[0];
                        end
                        n_csize[0] = sum;
                        n_cloc[0]  = loc;
                        n_flags[0] = 1'b1;
                    end else if (sum > r_csize[1]) begin
                        n_cpeaks = CNT_W'(2);
                        if (r_csize[1] != '0) begin
                            n_cpeaks   = CNT_W'(3);
                            n_csize[2] = r_csize[1];
                            n_cloc[2]  = r_cloc[1];
                            n_cocc[2]  = r_cocc[1];
                        end
                        n_csize[1] = sum;
                        n_cloc[1]  = loc;
                        n_flags[1] = 1'b1;
                    end else if (sum > r_csize[2]) begin
                        n_cpeaks   = CNT_W'(3);
                        n_csize[2] = sum;
                        n_cloc[2]  = loc;
                        n_flags[2] = 1'b1;
                    end
                end
            end
            n_hist = {r_hist[2:0], v};
            n_idx  = r_idx + IDX_W'(1);
        end

        // capture records before any clearing below
        if (i_item.action == ACT_FINISH) begin
            o_batch.kind  = KIND_BEST;
            o_batch.sec   = r_bsec;
            o_batch.ring  = r_bring;
            o_batch.size  = r_bsize;
            o_batch.loc   = r_bloc;
            o_batch.occ   = '0;
            o_batch.cnt   = '0;
            o_batch.total = '0;
        end else begin
            o_batch.kind  = KIND_CHAN;
            o_batch.sec   = {NRANK{i_item.sector}};
            o_batch.ring  = {NRANK{i_item.ring}};
            o_batch.size  = n_csize;
            o_batch.loc   = n_cloc;
            o_batch.occ   = n_cocc;
            o_batch.cnt   = n_cpeaks;
            o_batch.total = n_ctotal;
        end

        if (i_item.action == ACT_START ||
            (i_item.action == ACT_SAMPLE && i_item.channel_end)) begin
            n_hist   = '0;
            n_idx    = '0;
            n_run    = '0;
            n_flags  = '0;
            n_csize  = '0;
            n_cloc   = '0;
            n_cocc   = '0;
            n_cpeaks = '0;
            n_ctotal = '0;
        end
        if (i_item.action == ACT_START) begin
            n_bsize = '0;
            n_bsec  = '0;
            n_bring = '0;
            n_bloc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_idx    <= '0;
            r_run    <= '0;
            r_flags  <= '0;
            r_csize  <= '0;
            r_cloc   <= '0;
            r_cocc   <= '0;
            r_cpeaks <= '0;
            r_ctotal <= '0;
            r_bsize  <= '0;
            r_bsec   <= '0;
            r_bring  <= '0;
            r_bloc   <= '0;
        end else if (i_go) begin
            r_hist   <= n_hist;
            r_idx    <= n_idx;
            r_run    <= n_run;
            r_flags  <= n_flags;
            r_csize  <= n_csize;
            r_cloc   <= n_cloc;
            r_cocc   <= n_cocc;
            r_cpeaks <= n_cpeaks;
            r_ctotal <= n_ctotal;
            r_bsize  <= n_bsize;
            r_bsec   <= n_bsec;
            r_bring  <= n_bring;
            r_bloc   <= n_bloc;
        end
    end

endmodule

// File: rtl/spf_emit.sv
// Record batch register and rank serialiser for the output channel.
// Depends on spf_pkg and spf_if.
module spf_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  spf_pkg::t_batch i_batch,
    output logic            o_free,
    spf_out_if.source       o_rec
);
    import spf_pkg::*;

    spf_pkg::t_batch   r_batch;
    logic              r_full;
    logic [RANK_W-1:0] r_rank;
    logic              pop;

    assign pop    = r_full && o_rec.ready;
    assign o_free = !r_full || (pop && r_rank == RANK_LAST);

    assign o_rec.valid           = r_full;
    assign o_rec.record_kind     = r_batch.kind;
    assign o_rec.out_sector      = r_batch.sec[r_rank];
    assign o_rec.out_ring        = r_batch.ring[r_rank];
    assign o_rec.rank            = r_rank;
    assign o_rec.peak_size       = r_batch.size[r_rank];
    assign o_rec.peak_location   = r_batch.loc[r_rank];
    assign o_rec.peak_occupancy  = r_batch.occ[r_rank];
    assign o_rec.peak_count      = r_batch.cnt;
    assign o_rec.total_occupancy = r_batch.total;
    assign o_rec.last            = (r_rank == RANK_LAST);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_rank <= RANK_FIRST;
        end else if (pop) begin
            if (r_rank == RANK_LAST) begin
                r_rank <= RANK_FIRST;
                r_full <= i_load;
            end else begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end else if (i_load) begin
            r_full <= 1'b1;
        end
    end

endmodule

// File: rtl/sector_peak_finder_core.sv
// Top level of the sector peak finder: input register, tracker, record serialiser.
// Depends on spf_pkg, spf_if, spf_track, spf_emit and the assertion macro header.
//
//  port    | dir | carries
//  --------+-----+--------------------------------------------------------
//  i_smp   | in  | sample request: action, sector, ring, value, channel end
//  o_rec   | out | peak record: kind, tag, rank, size, location, occupancies
//
// A request is registered on acceptance and processed once the tracker takes
// it; one request per cycle is taken while it raises no records.
// A channel end or finish request fills the batch register, which serves its
// three records one rank at a time; the next such request waits for the
// batch to drain, so output stalls back up into i_smp.ready.
// Reset is synchronous and clears all tracking state at once, no clearing pass.
module sector_peak_finder_core #(
    parameter int MAX_SAMPLES = spf_pkg::DEF_MAX_SAMPLES,
    parameter int VALUE_BITS  = spf_pkg::DEF_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spf_in_if.sink     i_smp,
    spf_out_if.source  o_rec
);
    import spf_pkg::*;
    `include "sector_peak_finder_core_assert.svh"

    logic            r_in_valid;
    spf_pkg::t_item  r_in;
    spf_pkg::t_batch batch;
    logic            produces;
    logic            emit_free;
    logic            go;

    assign produces = (r_in.action == ACT_FINISH) ||
                      (r_in.action == ACT_SAMPLE && r_in.channel_end);
    assign go          = r_in_valid && (!produces || emit_free);
    assign i_smp.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_in.action       <= i_smp.action;
            r_in.sector       <= i_smp.sector;
            r_in.ring         <= i_smp.ring;
            r_in.sample_value <= i_smp.sample_value;
            r_in.channel_end  <= i_smp.channel_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.valid && i_smp.ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    spf_track #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .o_batch (batch)
    );

    spf_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go && produces),
        .i_batch (batch),
        .o_free  (emit_free),
        .o_rec   (o_rec)
    );

    // a batch never breaks off before its final rank
    `SPF_ASSERT_NEXT(a_batch_whole, i_clk, i_rst_n, o_rec.valid && o_rec.ready && !o_rec.last, o_rec.valid)

    `SPF_ASSERT_NEXT(a_rank_step, i_clk, i_rst_n, o_rec.valid && o_rec.ready && !o_rec.last, o_rec.rank == $past(o_rec.rank) + 2'd1)

    // event-wide records carry no channel figures
    `SPF_ASSERT_NOW(a_best_blank, i_clk, i_rst_n, o_rec.valid && o_rec.record_kind == KIND_BEST, o_rec.peak_occupancy == '0 && o_rec.peak_count == '0 && o_rec.total_occupancy == '0)

    `SPF_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, i_smp.valid && i_smp.ready, r_in_valid)

endmodule
